// ----- design/mtid_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtid_pkg
// Shared types, constants and the tempering function of the interval draw unit.
// ----------------------------------------------------------------------------
package mtid_pkg;

  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned ADDR_W       = $clog2(STATE_WORDS);

  localparam logic [31:0] INIT_MULT    = 32'd1812433253;
  localparam logic [31:0] TWIST_MATRIX = 32'h9908B0DF;
  localparam logic [31:0] TEMPER_B     = 32'h9D2C5680;
  localparam logic [31:0] TEMPER_C     = 32'hEFC60000;
  localparam logic [31:0] LOW_BITS     = 32'h7FFFFFFF;
  localparam logic [31:0] TOP_BIT      = 32'h80000000;
  localparam logic [31:0] SEED_RESET   = 32'd5489;

  // request kinds on the input channel
  localparam logic [1:0] KIND_RESEED  = 2'd0;
  localparam logic [1:0] KIND_RAW     = 2'd1;
  localparam logic [1:0] KIND_BOUNDED = 2'd2;

  typedef enum logic [1:0] {
    OP_RESEED,
    OP_RAW,
    OP_BOUNDED,
    OP_CONST
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] lo;    // lower bound, or constant result for OP_CONST
    logic [31:0] maxv;
    logic [31:0] mask;
  } entry_t;

  typedef enum logic [3:0] {
    B_SEED0,
    B_SEED_MUL,
    B_SEED_WR,
    B_SEED_DONE,
    B_IDLE,
    B_TW_START,
    B_TW_CUR,
    B_TW_RD,
    B_TW_WR,
    B_DRAW_RD,
    B_DRAW_USE
  } back_state_e;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ----- design/mtid_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtid_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mtid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ----- design/mtid_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtid_front
// Request classifier: sorts each request and prepares the bounded draw limits.
// ----------------------------------------------------------------------------
module mtid_front (
  input  logic [1:0]           kind_i,
  input  logic signed [31:0]   low_i,
  input  logic signed [31:0]   high_i,
  output mtid_pkg::entry_t     entry_o
);

  logic signed [32:0] diff;
  logic [31:0]        maxv;
  logic [31:0]        mask;

  always_comb begin
    diff = {high_i[31], high_i} - {low_i[31], low_i};
    maxv = 32'(diff - 33'sd1);
    mask = maxv;
    mask = mask | (mask >> 1);
    mask = mask | (mask >> 2);
    mask = mask | (mask >> 4);
    mask = mask | (mask >> 8);
    mask = mask | (mask >> 16);

    entry_o.lo   = low_i;
    entry_o.maxv = maxv;
    entry_o.mask = mask;
    unique case (kind_i)
      mtid_pkg::KIND_RESEED: entry_o.op = mtid_pkg::OP_RESEED;
      mtid_pkg::KIND_RAW:    entry_o.op = mtid_pkg::OP_RAW;
      mtid_pkg::KIND_BOUNDED: begin
        // empty or single-value range: answer low without drawing
        entry_o.op = (diff <= 33'sd1) ? mtid_pkg::OP_CONST : mtid_pkg::OP_BOUNDED;
      end
      default: begin
        entry_o.op = mtid_pkg::OP_CONST;
        entry_o.lo = '0;
      end
    endcase
  end

endmodule

// ----- design/mtid_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtid_queue
// Two-entry request queue between classifier and draw engine.
// ----------------------------------------------------------------------------
module mtid_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mtid_pkg::entry_t  entry_i,
  output logic              full_o,
  output logic              valid_o,
  output mtid_pkg::entry_t  entry_o,
  input  logic              pop_i
);

  mtid_pkg::entry_t slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign entry_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ----- design/mtid_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtid_back
// Draw engine: seeds, twists and tempers the state memory, runs rejection.
// ----------------------------------------------------------------------------
module mtid_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         seed_i,
  input  logic                q_valid_i,
  input  mtid_pkg::entry_t    q_entry_i,
  output logic                q_pop_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [31:0]         word_o,
  output logic signed [31:0]  number_o
);

  localparam int unsigned AW   = mtid_pkg::ADDR_W;
  localparam logic [AW-1:0] LAST  = AW'(mtid_pkg::STATE_WORDS - 1);
  localparam logic [AW-1:0] SPLIT = AW'(mtid_pkg::STATE_WORDS - mtid_pkg::TWIST_OFFSET);
  localparam logic [AW-1:0] OFFS  = AW'(mtid_pkg::TWIST_OFFSET);
  localparam logic [AW-1:0] PEND  = AW'(mtid_pkg::STATE_WORDS);

  mtid_pkg::back_state_e state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [31:0]   p_q, p_d;
  logic [31:0]   prod_q, prod_d;
  logic [31:0]   cur_q, cur_d;
  logic          by_req_q, by_req_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   word_q, word_d;
  logic [31:0]   number_q, number_d;

  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [31:0]   wdata, rdata_a, rdata_b;
  logic          out_free;
  logic [31:0]   y, tw, masked, mix;

  mtid_ram #(.WIDTH(32), .DEPTH(mtid_pkg::STATE_WORDS)) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign word_o      = word_q;
  assign number_o    = number_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    p_d         = p_q;
    cur_d       = cur_q;
    by_req_d    = by_req_q;
    out_valid_d = out_valid_q && out_stall_i;
    word_d      = word_q;
    number_d    = number_q;
    q_pop_o     = 1'b0;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = '0;
    raddr_a     = pos_q;
    raddr_b     = '0;
    mix         = p_q ^ (p_q >> 30);
    prod_d      = mix * mtid_pkg::INIT_MULT;
    y           = (cur_q & mtid_pkg::TOP_BIT) | (rdata_a & mtid_pkg::LOW_BITS);
    tw          = mtid_pkg::temper(rdata_a);
    masked      = tw & q_entry_i.mask;

    unique case (state_q)
      mtid_pkg::B_SEED0: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = p_q;
        idx_d   = AW'(1);
        state_d = mtid_pkg::B_SEED_MUL;
      end
      mtid_pkg::B_SEED_MUL: begin
        state_d = mtid_pkg::B_SEED_WR;
      end
      mtid_pkg::B_SEED_WR: begin
        we    = 1'b1;
        wdata = prod_q + 32'(idx_q);
        p_d   = wdata;
        if (idx_q == LAST) begin
          pos_d   = PEND;
          state_d = mtid_pkg::B_SEED_DONE;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = mtid_pkg::B_SEED_MUL;
        end
      end
      mtid_pkg::B_SEED_DONE: begin
        if (!by_req_q) begin
          state_d = mtid_pkg::B_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          word_d      = '0;
          number_d    = '0;
          q_pop_o     = 1'b1;
          by_req_d    = 1'b0;
          state_d     = mtid_pkg::B_IDLE;
        end
      end
      mtid_pkg::B_IDLE: begin
        if (q_valid_i) begin
          unique case (q_entry_i.op)
            mtid_pkg::OP_RESEED: begin
              p_d      = seed_i;
              by_req_d = 1'b1;
              state_d  = mtid_pkg::B_SEED0;
            end
            mtid_pkg::OP_RAW, mtid_pkg::OP_BOUNDED: begin
              state_d = (pos_q == PEND) ? mtid_pkg::B_TW_START : mtid_pkg::B_DRAW_RD;
            end
            mtid_pkg::OP_CONST: begin
              if (out_free) begin
                out_valid_d = 1'b1;
                word_d      = '0;
                number_d    = q_entry_i.lo;
                q_pop_o     = 1'b1;
              end
            end
          endcase
        end
      end
      mtid_pkg::B_TW_START: begin
        raddr_a = '0;
        idx_d   = '0;
        state_d = mtid_pkg::B_TW_CUR;
      end
      mtid_pkg::B_TW_CUR: begin
        cur_d   = rdata_a;
        state_d = mtid_pkg::B_TW_RD;
      end
      mtid_pkg::B_TW_RD: begin
        raddr_a = (idx_q == LAST) ? '0 : idx_q + AW'(1);
        raddr_b = (idx_q < SPLIT) ? idx_q + OFFS : idx_q - SPLIT;
        state_d = mtid_pkg::B_TW_WR;
      end
      mtid_pkg::B_TW_WR: begin
        we    = 1'b1;
        wdata = rdata_b ^ (y >> 1) ^ (y[0] ? mtid_pkg::TWIST_MATRIX : 32'd0);
        cur_d = rdata_a;
        if (idx_q == LAST) begin
          pos_d   = '0;
          state_d = mtid_pkg::B_DRAW_RD;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = mtid_pkg::B_TW_RD;
        end
      end
      mtid_pkg::B_DRAW_RD: begin
        state_d = mtid_pkg::B_DRAW_USE;
      end
      mtid_pkg::B_DRAW_USE: begin
        if (q_entry_i.op == mtid_pkg::OP_RAW) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            word_d      = tw;
            number_d    = '0;
            q_pop_o     = 1'b1;
            pos_d       = pos_q + AW'(1);
            state_d     = mtid_pkg::B_IDLE;
          end
        end else if (masked <= q_entry_i.maxv) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            word_d      = '0;
            number_d    = q_entry_i.lo + masked;
            q_pop_o     = 1'b1;
            pos_d       = pos_q + AW'(1);
            state_d     = mtid_pkg::B_IDLE;
          end
        end else begin
          // reject: advance and draw again
          pos_d   = pos_q + AW'(1);
          state_d = (pos_q == LAST) ? mtid_pkg::B_TW_START : mtid_pkg::B_DRAW_RD;
        end
      end
      default: state_d = mtid_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtid_pkg::B_SEED0;
      idx_q       <= '0;
      pos_q       <= PEND;
      p_q         <= mtid_pkg::SEED_RESET;
      by_req_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      p_q         <= p_d;
      by_req_q    <= by_req_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    cur_q    <= cur_d;
    word_q   <= word_d;
    number_q <= number_d;
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PEND) else $error("read position past state size");

  a_write_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q != mtid_pkg::B_IDLE && state_q != mtid_pkg::B_DRAW_USE))
    else $error("state memory written outside seed or twist");

  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i) else $error("pop from empty queue");

  a_pop_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> out_valid_q) else $error("request retired without result");

endmodule

// ----- design/mersenne_twister_interval_draw_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mersenne_twister_interval_draw_unit
// MT19937 generator serving reseed, raw word and bounded integer requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on valid_i/stall_o with kind_i, low_i, high_i; each gives
//   exactly one result on valid_o/stall_i with word_o and number_o.
//   kind 0 reseeds from the seed register, kind 1 returns a tempered word,
//   kind 2 returns an integer in [low, high). Kind 3 and ranges of at most one
//   value return at once without touching the state.
//   The engine serves one request at a time; a rejected bounded candidate
//   is followed by a fresh draw. Every 624 words a twist runs through the
//   dual-read state memory. A reseed rewrites the memory.
//   Reset: the state is seeded from 5489 right after reset; requests queue
//   up but are served once that finishes.
//   A stalled result holds in the output register; the engine waits for it,
//   while the two-entry request queue keeps accepting until full.
//   The seed register sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module mersenne_twister_interval_draw_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [1:0]         kind_i,
  input  logic signed [31:0] low_i,
  input  logic signed [31:0] high_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [31:0]        word_o,
  output logic signed [31:0] number_o
);

  logic [31:0]      seed_q;
  mtid_pkg::entry_t front_entry;
  mtid_pkg::entry_t head_entry;
  logic             q_full, q_valid, q_pop;

  // Register file: only the seed register exists, at byte address 0.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? seed_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= mtid_pkg::SEED_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      seed_q <= pwdata;
    end
  end

  // Classify each request on entry.
  mtid_front u_front (
    .kind_i (kind_i),
    .low_i  (low_i),
    .high_i (high_i),
    .entry_o(front_entry)
  );

  // Hold up to two classified requests for the engine.
  assign stall_o = q_full;

  mtid_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (valid_i),
    .entry_i(front_entry),
    .full_o (q_full),
    .valid_o(q_valid),
    .entry_o(head_entry),
    .pop_i  (q_pop)
  );

  // Seed, twist, temper and draw; retire one request per result.
  mtid_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .seed_i     (seed_q),
    .q_valid_i  (q_valid),
    .q_entry_i  (head_entry),
    .q_pop_o    (q_pop),
    .out_stall_i(stall_i),
    .out_valid_o(valid_o),
    .word_o     (word_o),
    .number_o   (number_o)
  );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 interval draw unit testbench
// Drives reseed, raw and bounded requests through the valid/stall channel,
// writes the seed register over APB between phases, and compares each result
// with a cycle-free predictor of the generator kept in this file.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned RANDOM_REQUESTS = 1000;
  localparam int unsigned CYCLE_LIMIT     = 900000;
  localparam int unsigned SETTLE_CYCLES   = 3000;

  typedef struct packed {
    logic [31:0] word;
    logic [31:0] number;
  } draw_result_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] low;
    logic [31:0] high;
    bit          known;   // result typed into the table
    logic [31:0] word;
    logic [31:0] number;
  } directed_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               valid_i;
  logic               stall_o;
  logic [1:0]         kind_i;
  logic signed [31:0] low_i;
  logic signed [31:0] high_i;
  logic               valid_o;
  logic               stall_i;
  logic [31:0]        word_o;
  logic signed [31:0] number_o;

  mersenne_twister_interval_draw_unit DUT (.*);

  // Predictor state: seed register copy, twister words and read position.
  logic [31:0] seed_copy;
  logic [31:0] mt_words [mtid_pkg::STATE_WORDS];
  int unsigned mt_pos;

  draw_result_t pending_draws[$];
  int unsigned  error_count;
  int unsigned  result_count;
  int unsigned  cycle_count;
  int unsigned  raw_count;
  int unsigned  bounded_count;
  int unsigned  reseed_count;
  bit           hold_off;      // long receiver stall requested
  bit           pattern_on;    // receiver pattern stalls enabled

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Fill the state from a seed with the 1812433253 recurrence.
  function automatic void init_state(input logic [31:0] s);
    mt_words[0] = s;
    for (int unsigned i = 1; i < mtid_pkg::STATE_WORDS; i++) begin
      mt_words[i] = mtid_pkg::INIT_MULT * (mt_words[i-1] ^ (mt_words[i-1] >> 30)) + i;
    end
    mt_pos = mtid_pkg::STATE_WORDS;
  endfunction

  // Twist when exhausted, then temper the next word.
  function automatic logic [31:0] next_tempered();
    logic [31:0] y;
    int unsigned nxt;
    int unsigned far_idx;
    if (mt_pos >= mtid_pkg::STATE_WORDS) begin
      for (int unsigned i = 0; i < mtid_pkg::STATE_WORDS; i++) begin
        nxt     = (i + 1) % mtid_pkg::STATE_WORDS;
        far_idx = (i + mtid_pkg::TWIST_OFFSET) % mtid_pkg::STATE_WORDS;
        y = (mt_words[i] & mtid_pkg::TOP_BIT) | (mt_words[nxt] & mtid_pkg::LOW_BITS);
        mt_words[i] = mt_words[far_idx] ^ (y >> 1)
                      ^ (y[0] ? mtid_pkg::TWIST_MATRIX : 32'h0);
      end
      mt_pos = 0;
    end
    y = mt_words[mt_pos];
    mt_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & mtid_pkg::TEMPER_B);
    y = y ^ ((y << 15) & mtid_pkg::TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // Work out the result of one request and advance the predictor state.
  function automatic draw_result_t predict_draw(input logic [1:0] kind,
                                                input logic [31:0] low,
                                                input logic [31:0] high);
    draw_result_t r;
    logic signed [32:0] span;
    logic [31:0] maxv;
    logic [31:0] mask;
    logic [31:0] v;
    r = '0;
    case (kind)
      mtid_pkg::KIND_RESEED: init_state(seed_copy);
      mtid_pkg::KIND_RAW:    r.word = next_tempered();
      mtid_pkg::KIND_BOUNDED: begin
        span = $signed({high[31], high}) - $signed({low[31], low});
        if (span <= 33'sd1) begin
          r.number = low;
        end else begin
          maxv = span[31:0] - 32'd1;
          mask = maxv;
          mask |= mask >> 1;
          mask |= mask >> 2;
          mask |= mask >> 4;
          mask |= mask >> 8;
          mask |= mask >> 16;
          do begin
            v = next_tempered() & mask;
          end while (v > maxv);
          r.number = low + v;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: stall at random under its own pattern, plus a long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_i <= 1'b0;
    end else begin
      stall_i <= hold_off || (pattern_on && ($urandom_range(0, 3) == 0));
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    draw_result_t exp_r;
    if (rst_ni && valid_o && !stall_i) begin
      result_count <= result_count + 1;
      if (pending_draws.size() == 0) begin
        $error("unexpected result word=%h number=%h", word_o, number_o);
        error_count++;
      end else begin
        exp_r = pending_draws.pop_front();
        if (word_o !== exp_r.word) begin
          $error("word: expected %h, got %h", exp_r.word, word_o);
          error_count++;
        end
        if (number_o !== exp_r.number) begin
          $error("number: expected %h, got %h", exp_r.number, number_o);
          error_count++;
        end
      end
    end
  end

  // Write the seed register: setup cycle, then access cycle.
  task automatic write_seed(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'd0;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    seed_copy = value;
  endtask

  // Offer one request and hold it until accepted; queue its expectation.
  task automatic send_request(input logic [1:0] kind, input logic [31:0] low,
                              input logic [31:0] high, input bit known,
                              input logic [31:0] word, input logic [31:0] number);
    draw_result_t r;
    valid_i <= 1'b1;
    kind_i  <= kind;
    low_i   <= low;
    high_i  <= high;
    do @(posedge clk_i); while (stall_o);
    r = predict_draw(kind, low, high);
    if (known) begin
      r.word   = word;
      r.number = number;
    end
    pending_draws.push_back(r);
    case (kind)
      mtid_pkg::KIND_RESEED:  reseed_count++;
      mtid_pkg::KIND_RAW:     raw_count++;
      mtid_pkg::KIND_BOUNDED: bounded_count++;
      default: ;
    endcase
  endtask

  task automatic drop_valid();
    valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_draws.size() != 0) @(posedge clk_i);
  endtask

  // Random bounds: mostly small spans, some wide, some empty, some near full width.
  task automatic random_bounds(output logic [31:0] low, output logic [31:0] high);
    low = $urandom();
    case ($urandom_range(0, 9))
      0:       high = $urandom();
      1:       begin low = 32'h8000_0000 | $urandom_range(0, 15);
                     high = 32'h7FFF_FFFF - $urandom_range(0, 15); end
      2:       high = low - $urandom_range(0, 3);
      3:       high = low + $urandom_range(1 << 20, 1 << 30);
      default: high = low + $urandom_range(2, 1000);
    endcase
  endtask

  directed_row_t directed_rows[] = '{
    // first raw word after reset from seed 5489
    '{mtid_pkg::KIND_RAW,     32'h0,         32'h0,         1'b1, 32'd3499211612, 32'h0},
    '{mtid_pkg::KIND_RAW,     32'h0,         32'h0,         1'b0, 32'h0, 32'h0},
    // empty, single-value and reversed ranges return low
    '{mtid_pkg::KIND_BOUNDED, 32'd5,         32'd5,         1'b1, 32'h0, 32'd5},
    '{mtid_pkg::KIND_BOUNDED, 32'd7,         32'd8,         1'b1, 32'h0, 32'd7},
    '{mtid_pkg::KIND_BOUNDED, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0, 32'h7FFF_FFFF},
    '{mtid_pkg::KIND_BOUNDED, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0, 32'hFFFF_FFFF},
    // unused kind leaves state alone
    '{2'd3,                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, 32'h0},
    '{mtid_pkg::KIND_BOUNDED, 32'd0,         32'd2,         1'b0, 32'h0, 32'h0},
    '{mtid_pkg::KIND_BOUNDED, 32'd0,         32'd3,         1'b0, 32'h0, 32'h0},
    '{mtid_pkg::KIND_BOUNDED, 32'hFFFF_FFF0, 32'd16,        1'b0, 32'h0, 32'h0},
    // full-width and half-width spans
    '{mtid_pkg::KIND_BOUNDED, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{mtid_pkg::KIND_BOUNDED, 32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{mtid_pkg::KIND_BOUNDED, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
    // reseed with the reset seed returns zeros, then the known first word
    '{mtid_pkg::KIND_RESEED,  32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1, 32'h0, 32'h0},
    '{mtid_pkg::KIND_RAW,     32'h0,         32'h0,         1'b1, 32'd3499211612, 32'h0},
    '{mtid_pkg::KIND_RAW,     32'h0,         32'h0,         1'b0, 32'h0, 32'h0}
  };

  initial begin
    logic [31:0] low;
    logic [31:0] high;
    logic [1:0]  kind;
    logic [31:0] seed_plan [4];
    int unsigned sent;
    int unsigned burst;

    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    valid_i    = 1'b0;
    kind_i     = '0;
    low_i      = '0;
    high_i     = '0;
    hold_off   = 1'b0;
    pattern_on = 1'b0;
    error_count = 0; result_count = 0; cycle_count = 0;
    raw_count = 0; bounded_count = 0; reseed_count = 0;
    seed_copy  = mtid_pkg::SEED_RESET;
    init_state(mtid_pkg::SEED_RESET);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, back to back, no stalls.
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].kind, directed_rows[i].low, directed_rows[i].high,
                   directed_rows[i].known, directed_rows[i].word, directed_rows[i].number);
    end
    drop_valid();
    wait_drained();

    // Fill the block: hold the receiver off while requests keep coming.
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 8; i++) begin
          send_request(mtid_pkg::KIND_RAW, '0, '0, 1'b0, '0, '0);
        end
        drop_valid();
      end
      begin
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    wait_drained();
    pattern_on = 1'b1;

    // Phases over several seeds, extremes among them; reseed opens each.
    seed_plan = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom(), mtid_pkg::SEED_RESET};
    sent = 0;
    foreach (seed_plan[p]) begin
      repeat (20) @(posedge clk_i);
      write_seed(seed_plan[p]);
      send_request(mtid_pkg::KIND_RESEED, $urandom(), $urandom(), 1'b0, '0, '0);
      while (sent < (p + 1) * RANDOM_REQUESTS / 4) begin
        burst = $urandom_range(1, 12);
        for (int unsigned b = 0; b < burst; b++) begin
          case ($urandom_range(0, 19))
            0:       kind = 2'd3;
            1:       kind = mtid_pkg::KIND_RESEED;
            2, 3, 4, 5, 6, 7: kind = mtid_pkg::KIND_RAW;
            default: kind = mtid_pkg::KIND_BOUNDED;
          endcase
          random_bounds(low, high);
          send_request(kind, low, high, 1'b0, '0, '0);
          sent++;
        end
        if ($urandom_range(0, 2) == 0) begin
          valid_i <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end
        // Occasionally pause until the block has drained.
        if ($urandom_range(0, 30) == 0) begin
          drop_valid();
          wait_drained();
        end
      end
      drop_valid();
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d raw, %0d bounded and %0d reseed requests, %0d results",
             raw_count, bounded_count, reseed_count, result_count);
    $display("seeds 0, all-ones, random and default, with long and patterned stalls");
    if (error_count == 0 && pending_draws.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/mtid_pkg.sv
design/mtid_ram.sv
design/mtid_front.sv
design/mtid_queue.sv
design/mtid_back.sv
design/mersenne_twister_interval_draw_unit.sv
tb/sv/testbench.sv
